FILE: rtl/cas_pkg.sv
// Shared types, constants and calendar helper functions for the calendar adder.
`default_nettype none

package cas_pkg;

	localparam int unsigned YEAR_W  = 10;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 15;
	localparam int unsigned DIV_W   = 32;
	localparam int unsigned CNT_W   = 1;
	localparam int unsigned REM_W   = 6;

	localparam logic [REM_W-1:0]   DIV_SIXTY  = 6'd60;
	localparam logic [REM_W-1:0]   DIV_DAY    = 6'd24;
	localparam logic [CNT_W-1:0]   DIV_LAST   = 1'b1;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
	localparam logic [MONTH_W-1:0] MONTHS     = 4'd12;
	localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 10'h3FF;

	// Reciprocals that give exact quotients for every 32-bit dividend:
	// x / 60 = (x * RECIP_SIXTY) >> 37 and x / 24 = (x * RECIP_DAY) >> 36.
	localparam logic [DIV_W-1:0]   RECIP_SIXTY = 32'h8888_8889;
	localparam logic [DIV_W-1:0]   RECIP_DAY   = 32'hAAAA_AAAB;
	localparam int unsigned        SHIFT_SIXTY = 37;
	localparam int unsigned        SHIFT_DAY   = 36;

	typedef struct packed {
		logic [9:0]  year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
		logic [30:0] add_seconds;
	} cas_in_t;

	typedef struct packed {
		logic [9:0] year_out;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
		logic       year_overflow;
	} cas_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_FINISH
	} cas_state_t;

	typedef enum logic [1:0] {
		PH_SEC,
		PH_MIN,
		PH_HOUR
	} cas_phase_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic walk_step;
		logic out_load;
	} cas_cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic out_busy;
	} cas_sts_t;

	// Years are counted from 1900, so the year 1900 + y is a multiple of four
	// exactly when y is. Within 1900..2923 the century years that are not
	// leap years are listed directly.
	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		logic century;
		century = (year == 10'd0)   || (year == 10'd200) || (year == 10'd300) ||
		          (year == 10'd400) || (year == 10'd600) || (year == 10'd700) ||
		          (year == 10'd800) || (year == 10'd1000);
		return (year[1:0] == 2'b00) && !century;
	endfunction

	function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] month,
	                                          input logic [YEAR_W-1:0] year);
		logic [4:0] len;
		unique case (month)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
			4'd1:                                      len = is_leap(year) ? 5'd29 : 5'd28;
			default:                                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cas_stream_if.sv
// Valid/ready stream interface that carries one payload item per handshake.
`default_nettype none

interface cas_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cas_ctrl.sv
// Controller state machine that sequences the carry divisions and the month walk.
`default_nettype none

module cas_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cas_pkg::cas_sts_t sts,
	output cas_pkg::cas_cmd_t      cmd
);
	import cas_pkg::*;

	cas_state_t state_q;
	cas_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_WALK: begin
				cmd.walk_step = !sts.walk_done;
			end
			ST_FINISH: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("division finished outside the division state");
`endif

endmodule

`default_nettype wire

FILE: rtl/cas_dp.sv
// Datapath: shared reciprocal divider for the time carries, month walker, result register.
`default_nettype none

module cas_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cas_pkg::cas_cmd_t cmd,
	output cas_pkg::cas_sts_t      sts,
	input  wire cas_pkg::cas_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cas_pkg::cas_out_t      out_data
);
	import cas_pkg::*;

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [4:0]         hour_q;
	logic [5:0]         min_q;
	logic [5:0]         sec_q;
	logic               ovf_q;

	logic [DIV_W-1:0]   div_num_q;
	logic [DIV_W-1:0]   quot_q;
	logic [CNT_W-1:0]   div_cnt_q;
	cas_phase_t         phase_q;

	logic               out_valid_q;
	cas_out_t           out_data_q;

	logic [REM_W-1:0]   divisor;
	logic [DIV_W-1:0]   recip;
	logic [2*DIV_W-1:0] mul_prod;
	logic [DIV_W-1:0]   quot;
	logic [REM_W-1:0]   rem_new;
	logic               div_last;
	logic [4:0]         dim;
	logic               walk_done;
	logic               month_wrap_in;

	always_comb begin
		divisor   = (phase_q == PH_HOUR) ? DIV_DAY : DIV_SIXTY;
		recip     = (phase_q == PH_HOUR) ? RECIP_DAY : RECIP_SIXTY;
		mul_prod  = (2*DIV_W)'(div_num_q) * (2*DIV_W)'(recip);
		quot      = (phase_q == PH_HOUR) ? DIV_W'(mul_prod >> SHIFT_DAY)
		                                 : DIV_W'(mul_prod >> SHIFT_SIXTY);
		// The remainder is below 64, so the low bits of the difference suffice.
		rem_new   = div_num_q[REM_W-1:0] - REM_W'(quot_q[REM_W-1:0] * divisor);
		div_last  = (div_cnt_q == DIV_LAST);
		dim       = month_days(month_q, year_q);
		walk_done = (day_q <= DAY_W'(dim));
		month_wrap_in = (in_data.month_in >= MONTHS);
	end

	assign sts.div_done  = div_last && (phase_q == PH_HOUR);
	assign sts.walk_done = walk_done;
	assign sts.out_busy  = out_valid_q && !out_ready;

	// Divider control: step counter and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			phase_q   <= PH_SEC;
		end else if (cmd.load) begin
			div_cnt_q <= '0;
			phase_q   <= PH_SEC;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (div_last) begin
				unique case (phase_q)
					PH_SEC:  phase_q <= PH_MIN;
					PH_MIN:  phase_q <= PH_HOUR;
					default: phase_q <= PH_HOUR;
				endcase
			end
		end
	end

	// Working registers. Each division takes two steps: the first registers the
	// quotient from the reciprocal product, the second forms the remainder and
	// adds the quotient to the next field up, which becomes the next dividend.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (month_wrap_in) begin
				month_q <= in_data.month_in - MONTHS;
				year_q  <= in_data.year_in + 1'b1;
				ovf_q   <= (in_data.year_in == YEAR_MAX);
			end else begin
				month_q <= in_data.month_in;
				year_q  <= in_data.year_in;
				ovf_q   <= 1'b0;
			end
			day_q     <= DAY_W'(in_data.day_in);
			hour_q    <= in_data.hour_in;
			min_q     <= in_data.minute_in;
			sec_q     <= '0;
			div_num_q <= DIV_W'(in_data.second_in) + DIV_W'(in_data.add_seconds);
			quot_q    <= '0;
		end else if (cmd.div_step) begin
			if (div_last) begin
				case (phase_q)
					PH_SEC: begin
						sec_q     <= rem_new;
						div_num_q <= quot_q + DIV_W'(min_q);
					end
					PH_MIN: begin
						min_q     <= rem_new;
						div_num_q <= quot_q + DIV_W'(hour_q);
					end
					default: begin
						hour_q    <= rem_new[4:0];
						day_q     <= day_q + quot_q[DAY_W-1:0];
						div_num_q <= quot_q;
					end
				endcase
			end else begin
				quot_q <= quot;
			end
		end else if (cmd.walk_step) begin
			day_q <= day_q - DAY_W'(dim);
			if (month_q == LAST_MONTH) begin
				month_q <= '0;
				year_q  <= year_q + 1'b1;
				if (year_q == YEAR_MAX) ovf_q <= 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.year_out      <= year_q;
			out_data_q.month_out     <= month_q;
			out_data_q.day_out       <= day_q[4:0];
			out_data_q.hour_out      <= hour_q;
			out_data_q.minute_out    <= min_q;
			out_data_q.second_out    <= sec_q;
			out_data_q.year_overflow <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_month_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> month_q <= LAST_MONTH)
		else $error("month left its range during the walk");
	a_time_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (sec_q < 6'd60) && (min_q < 6'd60) && (hour_q < 5'd24))
		else $error("time fields not normalized at result load");
	a_walk_shrinks_day: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |=> day_q < $past(day_q))
		else $error("month walk did not reduce the day count");
`endif

endmodule

`default_nettype wire

FILE: rtl/calendar_add_seconds.sv
// Top level of the calendar adder: adds a second count to a broken-down date and time.
//
//   channel  role    payload
//   req      sink    cas_in_t  : date, time and seconds to add
//   rsp      source  cas_out_t : later date and time, year overflow flag
//
// One item at a time: an accept state, then the three carries (by 60, 60 and 24,
// each a reciprocal multiply and then a remainder step), then the month walk, one
// month per step, then a load of the result register. The month walk dominates:
// the largest add walks about 820 months through the shared day register.
// Reset clears the controller and the result valid flag; no clearing pass.
// A stalled result holds in its register; the next item is taken once it has loaded.
`default_nettype none

module calendar_add_seconds (
	input wire logic     clk,
	input wire logic     arst_n,
	cas_stream_if.sink   req,
	cas_stream_if.source rsp
);
	import cas_pkg::*;

	cas_cmd_t cmd;
	cas_sts_t sts;
	logic     in_ready;
	cas_in_t  in_data;
	cas_out_t out_data;
	logic     out_valid;

	assign in_data   = req.data;
	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_data;

	cas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cas_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: test/calendar_add_seconds_tb.sv
// Self-checking testbench for the calendar adder: directed date cases, then random requests.
module calendar_add_seconds_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cas_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int unsigned RANDOM_ITEMS = 555;
	localparam int unsigned DRAIN_CYCLES = 1100;
	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned IDLE_PCT     = 23;
	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		cas_in_t  stim;
		bit       typed;
		cas_out_t res;
	} date_case_t;

	logic clk;
	logic arst_n;

	cas_stream_if #(.payload_t(cas_in_t))  req_if ();
	cas_stream_if #(.payload_t(cas_out_t)) rsp_if ();

	calendar_add_seconds uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cas_out_t   later_dates_q[$];
	date_case_t date_cases[$];
	int unsigned errors;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned year_wraps;
	int unsigned wide_adds;
	int unsigned cycles;
	bit          sender_may_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit gregorian_leap(input int unsigned yr);
		int unsigned full;
		full = yr + 1900;
		return (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
		if (mo == FEBRUARY && gregorian_leap(yr))
			return 29;
		return MONTH_LEN[mo % 12];
	endfunction

	// Carries the time fields upward, then walks whole months off the day count.
	function automatic cas_out_t calendar_advance(input cas_in_t t);
		int unsigned     yr;
		int unsigned     mo;
		int unsigned     dim;
		longint unsigned dy;
		longint unsigned hr;
		longint unsigned mn;
		longint unsigned sc;
		bit              ovf;
		cas_out_t        r;
		yr = t.year_in;
		mo = t.month_in;
		dy = t.day_in;
		hr = t.hour_in;
		mn = t.minute_in;
		sc = t.second_in;
		sc += t.add_seconds;
		ovf = 1'b0;
		if (mo >= MONTHS) begin
			mo -= MONTHS;
			if (yr == YEAR_MAX)
				ovf = 1'b1;
			yr = (yr + 1) % 1024;
		end
		mn += sc / 60;
		sc %= 60;
		hr += mn / 60;
		mn %= 60;
		dy += hr / 24;
		hr %= 24;
		dim = month_length(mo, yr);
		while (dy > dim) begin
			dy -= dim;
			mo++;
			if (mo >= MONTHS) begin
				mo = 0;
				if (yr == YEAR_MAX)
					ovf = 1'b1;
				yr = (yr + 1) % 1024;
			end
			dim = month_length(mo, yr);
		end
		r.year_out      = 10'(yr);
		r.month_out     = 4'(mo);
		r.day_out       = 5'(dy);
		r.hour_out      = 5'(hr);
		r.minute_out    = 6'(mn);
		r.second_out    = 6'(sc);
		r.year_overflow = ovf;
		return r;
	endfunction

	function automatic cas_in_t date_in(input int unsigned y, mo, d, h, mi, s, add);
		cas_in_t t;
		t.year_in     = 10'(y);
		t.month_in    = 4'(mo);
		t.day_in      = 5'(d);
		t.hour_in     = 5'(h);
		t.minute_in   = 6'(mi);
		t.second_in   = 6'(s);
		t.add_seconds = 31'(add);
		return t;
	endfunction

	function automatic cas_out_t date_out(input int unsigned y, mo, d, h, mi, s, ovf);
		cas_out_t r;
		r.year_out      = 10'(y);
		r.month_out     = 4'(mo);
		r.day_out       = 5'(d);
		r.hour_out      = 5'(h);
		r.minute_out    = 6'(mi);
		r.second_out    = 6'(s);
		r.year_overflow = ovf[0];
		return r;
	endfunction

	// Mostly normalized dates, a share of them near the year wrap, and some
	// with every field drawn over its full encoding. Most adds span days to months; a few
	// use the full width so the long month walk is exercised.
	function automatic cas_in_t random_request();
		cas_in_t     t;
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		if (pick < 10) begin
			t.year_in   = 10'($urandom_range(1023));
			t.month_in  = 4'($urandom_range(15));
			t.day_in    = 5'($urandom_range(31));
			t.hour_in   = 5'($urandom_range(31));
			t.minute_in = 6'($urandom_range(63));
			t.second_in = 6'($urandom_range(63));
		end else begin
			if (pick < 25) begin
				t.year_in  = 10'(1023 - $urandom_range(2));
				t.month_in = 4'($urandom_range(11, 10));
			end else begin
				t.year_in  = 10'($urandom_range(1023));
				t.month_in = 4'($urandom_range(11));
			end
			t.day_in    = 5'($urandom_range(month_length(t.month_in, t.year_in), 1));
			t.hour_in   = 5'($urandom_range(23));
			t.minute_in = 6'($urandom_range(59));
			t.second_in = 6'($urandom_range(59));
		end
		span = $urandom_range(99);
		if (span < 45)
			t.add_seconds = 31'($urandom_range(SECS_PER_DAY * 40));
		else if (span < 75)
			t.add_seconds = 31'($urandom_range(1 << 25));
		else if (span < 88)
			t.add_seconds = 31'($urandom);
		else if (span < 94)
			t.add_seconds = 31'($urandom_range(400) * SECS_PER_DAY + $urandom_range(2));
		else
			t.add_seconds = 31'h7FFF_FFFF - 31'($urandom_range(SECS_PER_DAY));
		return t;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic compare_date(input cas_out_t want, input cas_out_t got);
		check_field("year_out", want.year_out, got.year_out);
		check_field("month_out", want.month_out, got.month_out);
		check_field("day_out", want.day_out, got.day_out);
		check_field("hour_out", want.hour_out, got.hour_out);
		check_field("minute_out", want.minute_out, got.minute_out);
		check_field("second_out", want.second_out, got.second_out);
		check_field("year_overflow", want.year_overflow, got.year_overflow);
	endtask

	// Offers one item and records the later date it should produce once the
	// handshake completes. Valid stays high into the next item unless an idle
	// gap is drawn.
	task automatic offer_date(input cas_in_t item, input bit typed, input cas_out_t typed_res);
		while (sender_may_idle && $urandom_range(99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		do @(posedge clk); while (!req_if.ready);
		later_dates_q.push_back(typed ? typed_res : calendar_advance(item));
		items_sent++;
		if (item.add_seconds[30:27] != 4'd0)
			wide_adds++;
	endtask

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[calendar_add_seconds] ERROR");
		$finish;
	end

	// Checks each result and draws the next ready in the same process, so the
	// long hold-off and the stall-free stretch follow the result count exactly.
	initial begin : result_side
		cas_out_t    want;
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held = 1'b0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (later_dates_q.size() == 0) begin
					$error("result arrived with no item outstanding");
					errors++;
				end else begin
					want = later_dates_q.pop_front();
					compare_date(want, rsp_if.data);
					results_seen++;
					if (want.year_overflow)
						year_wraps++;
				end
			end
			if (!held && results_seen >= 25) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (results_seen >= 300 && results_seen < 400) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		year_wraps = 0;
		wide_adds = 0;
		sender_may_idle = 1'b1;

		date_cases.push_back('{date_in(0, 0, 0, 0, 0, 0, 0), 1, date_out(0, 0, 0, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(0, 0, 1, 0, 0, 0, 0), 1, date_out(0, 0, 1, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(1023, 11, 31, 23, 59, 59, 1), 1,
		                       date_out(0, 0, 1, 0, 0, 0, 1)});
		date_cases.push_back('{date_in(1023, 11, 31, 0, 0, 0, 0), 1,
		                       date_out(1023, 11, 31, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(0, 0, 1, 0, 0, 0, 32'h7FFF_FFFF), 0, '0});
		date_cases.push_back('{date_in(1023, 11, 31, 23, 59, 59, 32'h7FFF_FFFF), 0, '0});
		// Months twelve and up carry a year before anything else.
		date_cases.push_back('{date_in(5, 12, 1, 0, 0, 0, 0), 1, date_out(6, 0, 1, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(1023, 15, 10, 0, 0, 0, 0), 1,
		                       date_out(0, 3, 10, 0, 0, 0, 1)});
		date_cases.push_back('{date_in(20, 3, 5, 31, 63, 63, 0), 0, '0});
		date_cases.push_back('{date_in(100, 1, 31, 0, 0, 0, 0), 0, '0});
		// February 28 plus one day across the century rules.
		date_cases.push_back('{date_in(0, 1, 28, 0, 0, 0, SECS_PER_DAY), 1,
		                       date_out(0, 2, 1, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(100, 1, 28, 0, 0, 0, SECS_PER_DAY), 1,
		                       date_out(100, 1, 29, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(200, 1, 28, 0, 0, 0, SECS_PER_DAY), 1,
		                       date_out(200, 2, 1, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(104, 1, 28, 0, 0, 0, SECS_PER_DAY), 1,
		                       date_out(104, 1, 29, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(500, 1, 28, 0, 0, 0, SECS_PER_DAY), 1,
		                       date_out(500, 1, 29, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(700, 1, 29, 0, 0, 0, 0), 0, '0});
		date_cases.push_back('{date_in(3, 6, 0, 0, 0, 0, 0), 1, date_out(3, 6, 0, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(3, 6, 0, 0, 0, 0, SECS_PER_DAY), 0, '0});
		date_cases.push_back('{date_in(50, 4, 15, 10, 20, 30, 59), 0, '0});
		date_cases.push_back('{date_in(50, 4, 15, 10, 20, 30, 60), 0, '0});
		date_cases.push_back('{date_in(50, 4, 15, 10, 20, 30, 3599), 0, '0});
		date_cases.push_back('{date_in(50, 4, 15, 10, 20, 30, SECS_PER_DAY - 1), 0, '0});
		date_cases.push_back('{date_in(1023, 15, 31, 31, 63, 63, 32'h7FFF_FFFF), 0, '0});
		date_cases.push_back('{date_in(500, 11, 31, 12, 0, 0, SECS_PER_DAY / 2), 1,
		                       date_out(501, 0, 1, 0, 0, 0, 0)});
		date_cases.push_back('{date_in(10, 0, 31, 0, 0, 0, 365 * SECS_PER_DAY), 0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (date_cases[i])
			offer_date(date_cases[i].stim, date_cases[i].typed, date_cases[i].res);

		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			sender_may_idle = !(i >= 300 && i < 400);
			offer_date(random_request(), 1'b0, '0);
		end
		req_if.valid <= 1'b0;

		while (later_dates_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d dates, checked %0d results: %0d wrapped the year, %0d had wide adds.",
		         items_sent, results_seen, year_wraps, wide_adds);
		if (errors == 0)
			$display("[calendar_add_seconds] OK");
		else
			$display("[calendar_add_seconds] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cas_pkg.sv
rtl/cas_stream_if.sv
rtl/cas_ctrl.sv
rtl/cas_dp.sv
rtl/calendar_add_seconds.sv
test/calendar_add_seconds_tb.sv
